### src/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

### src/mde_pkg.sv
`default_nettype none

package mde_pkg;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0a;
    localparam logic [5:0] OP_SLTIU   = 6'h0b;
    localparam logic [5:0] OP_ANDI    = 6'h0c;
    localparam logic [5:0] OP_ORI     = 6'h0d;
    localparam logic [5:0] OP_LUI     = 6'h0f;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_SW      = 6'h2b;
    localparam logic [5:0] OP_LL      = 6'h30;

    // special function codes
    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [1:0] MEM_NONE  = 2'd0;
    localparam logic [1:0] MEM_LOAD  = 2'd1;
    localparam logic [1:0] MEM_STORE = 2'd2;

    localparam logic [4:0] LINK_REG = 5'd31;

    typedef enum logic [3:0] {
        ALU_ZERO,
        ALU_ADD,
        ALU_SUB,
        ALU_AND,
        ALU_OR,
        ALU_NOR,
        ALU_SLT,
        ALU_SLTU,
        ALU_SLL,
        ALU_SRL,
        ALU_PASSB,
        ALU_BEQ,
        ALU_BNE,
        ALU_J,
        ALU_JAL,
        ALU_JR
    } t_alu_op;

    // decoded item between front and back
    typedef struct packed {
        t_alu_op     alu_op;
        logic [31:0] opnd_a;
        logic [31:0] opnd_b;
        logic [4:0]  shamt;
        logic [15:0] imm;
        logic [25:0] jidx;
        logic [31:0] pc;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic [1:0]  mem_op;
        logic [31:0] store_data;
    } t_uop;

    typedef struct packed {
        logic [31:0] target_pc;
        logic        redirect;
        logic [31:0] store_data;
        logic [1:0]  mem_op;
        logic        reg_write;
        logic [4:0]  dest_reg;
        logic [31:0] result_value;
    } t_result;

endpackage

`default_nettype wire

### src/mde_front.sv
`default_nettype none

module mde_front
    import mde_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_instr,
    input  wire logic [31:0] i_instr_pc,
    input  wire logic [31:0] i_rs_value,
    input  wire logic [31:0] i_rt_value,
    output logic             o_valid,
    input  wire logic        i_ready,
    output t_uop             o_uop
);

    logic        r_valid;
    t_uop        r_uop;
    t_uop        n_uop;
    logic [5:0]  opcode;
    logic [5:0]  funct;
    logic [31:0] simm;
    logic [31:0] zimm;

    assign opcode = i_instr[31:26];
    assign funct  = i_instr[5:0];
    assign simm   = {{16{i_instr[15]}}, i_instr[15:0]};
    assign zimm   = {16'h0000, i_instr[15:0]};

    always_comb begin
        n_uop            = '0;
        n_uop.alu_op     = ALU_ZERO;
        n_uop.opnd_a     = i_rs_value;
        n_uop.opnd_b     = i_rt_value;
        n_uop.shamt      = i_instr[10:6];
        n_uop.imm        = i_instr[15:0];
        n_uop.jidx       = i_instr[25:0];
        n_uop.pc         = i_instr_pc;
        n_uop.dest_reg   = i_instr[20:16];
        n_uop.reg_write  = 1'b1;
        n_uop.mem_op     = MEM_NONE;
        n_uop.store_data = '0;
        if (opcode == OP_SPECIAL) begin
            n_uop.dest_reg = i_instr[15:11];
            case (funct)
                FN_ADD, FN_ADDU: n_uop.alu_op = ALU_ADD;
                FN_SUB, FN_SUBU: n_uop.alu_op = ALU_SUB;
                FN_AND:          n_uop.alu_op = ALU_AND;
                FN_OR:           n_uop.alu_op = ALU_OR;
                FN_NOR:          n_uop.alu_op = ALU_NOR;
                FN_SLT:          n_uop.alu_op = ALU_SLT;
                FN_SLTU:         n_uop.alu_op = ALU_SLTU;
                FN_SLL:          n_uop.alu_op = ALU_SLL;
                FN_SRL:          n_uop.alu_op = ALU_SRL;
                FN_JR: begin
                    n_uop.alu_op    = ALU_JR;
                    n_uop.reg_write = 1'b0;
                end
                default:         n_uop.alu_op = ALU_ZERO;
            endcase
        end else begin
            case (opcode)
                OP_ADDI, OP_ADDIU: begin
                    n_uop.alu_op = ALU_ADD;
                    n_uop.opnd_b = simm;
                end
                OP_ANDI: begin
                    n_uop.alu_op = ALU_AND;
                    n_uop.opnd_b = zimm;
                end
                OP_ORI: begin
                    n_uop.alu_op = ALU_OR;
                    n_uop.opnd_b = zimm;
                end
                OP_SLTI: begin
                    n_uop.alu_op = ALU_SLT;
                    n_uop.opnd_b = simm;
                end
                OP_SLTIU: begin
                    n_uop.alu_op = ALU_SLTU;
                    n_uop.opnd_b = simm;
                end
                OP_LUI: begin
                    n_uop.alu_op = ALU_PASSB;
                    n_uop.opnd_b = {i_instr[15:0], 16'h0000};
                end
                OP_LW, OP_LL: begin
                    n_uop.alu_op = ALU_ADD;
                    n_uop.opnd_b = simm;
                    n_uop.mem_op = MEM_LOAD;
                end
                OP_SW: begin
                    n_uop.alu_op     = ALU_ADD;
                    n_uop.opnd_b     = simm;
                    n_uop.mem_op     = MEM_STORE;
                    n_uop.reg_write  = 1'b0;
                    n_uop.store_data = i_rt_value;
                end
                OP_BEQ: begin
                    n_uop.alu_op    = ALU_BEQ;
                    n_uop.reg_write = 1'b0;
                end
                OP_BNE: begin
                    n_uop.alu_op    = ALU_BNE;
                    n_uop.reg_write = 1'b0;
                end
                OP_J: begin
                    n_uop.alu_op    = ALU_J;
                    n_uop.reg_write = 1'b0;
                end
                OP_JAL: begin
                    n_uop.alu_op   = ALU_JAL;
                    n_uop.dest_reg = LINK_REG;
                end
                default: n_uop.alu_op = ALU_ZERO;
            endcase
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_uop   = r_uop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_uop <= n_uop;
        end
    end

endmodule

`default_nettype wire

### src/mde_queue.sv
`default_nettype none

module mde_queue
    import mde_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_uop i_uop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_uop      o_uop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_uop             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_uop   = r_mem[r_rd_ptr];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_uop;
        end
    end

endmodule

`default_nettype wire

### src/mde_back.sv
`default_nettype none

module mde_back
    import mde_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_uop i_uop,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_result   o_res
);

    logic        r_valid;
    t_result     r_res;
    t_result     n_res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] pc_plus4;
    logic [31:0] br_offset;
    logic        equal;
    logic        taken;

    assign a         = i_uop.opnd_a;
    assign b         = i_uop.opnd_b;
    assign pc_plus4  = i_uop.pc + 32'd4;
    assign br_offset = {{14{i_uop.imm[15]}}, i_uop.imm, 2'b00};
    assign equal     = (a == b);
    assign taken     = (i_uop.alu_op == ALU_BEQ) ? equal : !equal;

    always_comb begin
        n_res              = '0;
        n_res.dest_reg     = i_uop.dest_reg;
        n_res.reg_write    = i_uop.reg_write;
        n_res.mem_op       = i_uop.mem_op;
        n_res.store_data   = i_uop.store_data;
        case (i_uop.alu_op)
            ALU_ADD:   n_res.result_value = a + b;
            ALU_SUB:   n_res.result_value = a - b;
            ALU_AND:   n_res.result_value = a & b;
            ALU_OR:    n_res.result_value = a | b;
            ALU_NOR:   n_res.result_value = ~(a | b);
            ALU_SLT:   n_res.result_value = {31'd0, $signed(a) < $signed(b)};
            ALU_SLTU:  n_res.result_value = {31'd0, a < b};
            ALU_SLL:   n_res.result_value = b << i_uop.shamt;
            ALU_SRL:   n_res.result_value = b >> i_uop.shamt;
            ALU_PASSB: n_res.result_value = b;
            ALU_BEQ, ALU_BNE: begin
                n_res.result_value = {31'd0, taken};
                n_res.redirect     = taken;
                n_res.target_pc    = taken ? pc_plus4 + br_offset : '0;
            end
            ALU_J: begin
                n_res.redirect  = 1'b1;
                n_res.target_pc = {pc_plus4[31:28], i_uop.jidx, 2'b00};
            end
            ALU_JAL: begin
                n_res.result_value = i_uop.pc + 32'd8;
                n_res.redirect     = 1'b1;
                n_res.target_pc    = {pc_plus4[31:28], i_uop.jidx, 2'b00};
            end
            ALU_JR: begin
                n_res.redirect  = 1'b1;
                n_res.target_pc = a;
            end
            default:   n_res.result_value = '0;
        endcase
    end

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end

endmodule

`default_nettype wire

### src/mips_decode_execute.sv
`default_nettype none

// MIPS32 integer decode/execute: each item carries an instruction word, its pc and the
// rs/rt register values, and yields one result item with the ALU value or memory address,
// destination register and write enable, memory operation, store data, and redirect with
// its target. One item is taken every clock cycle while decode can accept; the item is
// registered in decode at the edge that accepts it, then written into the queue, then into
// the execute output register, each step waiting while the next is stalled. Decode and
// execute take a new item each cycle while empty or draining, the queue while not full.
// A queue of QUEUE_DEPTH decoded items between decode and execute lets the two sides stall
// independently. There is no reset-time clearing pass.
module mips_decode_execute
    import mde_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // instr [31:0], instr_pc [63:32], rs_value [95:64], rt_value [127:96]
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // result_value [31:0], dest_reg [36:32], reg_write [37], mem_op [39:38],
    // store_data [71:40], redirect [72], target_pc [104:73], zero [111:105]
    output logic [111:0]      m_axis_tdata
);

`include "assert_macros.svh"

    logic    fr_valid;
    logic    fr_ready;
    t_uop    fr_uop;
    logic    q_valid;
    logic    q_ready;
    t_uop    q_uop;
    t_result bk_res;
    logic    in_take;
    logic    fr_stall;
    logic    out_link;
    logic    mem_ok;

    mde_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_instr    (s_axis_tdata[31:0]),
        .i_instr_pc (s_axis_tdata[63:32]),
        .i_rs_value (s_axis_tdata[95:64]),
        .i_rt_value (s_axis_tdata[127:96]),
        .o_valid    (fr_valid),
        .i_ready    (fr_ready),
        .o_uop      (fr_uop)
    );

    mde_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (fr_valid),
        .o_ready (fr_ready),
        .i_uop   (fr_uop),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_uop   (q_uop)
    );

    mde_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_ready),
        .i_uop   (q_uop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (bk_res)
    );

    assign m_axis_tdata = {7'd0, bk_res};

    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign fr_stall = fr_valid && !fr_ready;
    assign out_link = m_axis_tvalid && bk_res.redirect && bk_res.reg_write;
    assign mem_ok   = (bk_res.mem_op == MEM_NONE) || (bk_res.mem_op == MEM_LOAD) ||
                      (bk_res.mem_op == MEM_STORE && !bk_res.reg_write);

    // an accepted item is held by decode on the next cycle
    `ASSERT_NEXT(a_front_load, i_clk, i_rst_n, in_take, fr_valid, "item lost")
    // decode keeps its item while the queue is full
    `ASSERT_NEXT(a_front_hold, i_clk, i_rst_n, fr_stall, fr_valid && $stable(fr_uop), "item lost")
    // only jal both redirects and writes, and it writes the link register
    `ASSERT_IMPLIES(a_link_dest, i_clk, i_rst_n, out_link, bk_res.dest_reg == LINK_REG, "bad link")
    // stores never write a register and the memory code is legal
    `ASSERT_IMPLIES(a_mem_op, i_clk, i_rst_n, m_axis_tvalid, mem_ok, "bad memory operation")

endmodule

`default_nettype wire
